/* hdl/hba_pkg.sv */
// shared types and constants of the histogram bin accumulator
`timescale 1ns / 1ps

package hba_pkg;

    localparam int MAX_BINS = 4096;
    localparam int ADDR_W   = $clog2(MAX_BINS);
    localparam int SQ_W     = 2 * ADDR_W;
    localparam int NB_W     = 13;
    localparam int BIN_W    = 17;
    localparam int RIDX_W   = 12;
    localparam int LIM_W    = BIN_W + 1;

    localparam logic [NB_W-1:0] NUM_BINS_RST = NB_W'(4096);

    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic load;
        logic lookup;
        logic update;
        logic clear;
        logic clr_begin;
        logic clr_report;
    } t_dp_cmd;

    typedef struct packed {
        logic start_clear;
        logic clr_last;
    } t_dp_status;

endpackage

/* hdl/hba_ctrl.sv */
// sequencing state machine of the histogram bin accumulator
`timescale 1ns / 1ps

module hba_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  hba_pkg::t_dp_status i_status,
    output hba_pkg::t_dp_cmd   o_cmd,
    output logic               o_busy
);

    hba_pkg::t_state r_state, n_state;
    logic            r_report, n_report;
    logic            accept;

    assign accept = (r_state == hba_pkg::ST_IDLE) && i_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= hba_pkg::ST_CLEAR;   // clearing pass after reset
            r_report <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_report <= n_report;
        end
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_report = r_report;
        unique case (r_state)
            hba_pkg::ST_IDLE: begin
                if (i_start) begin
                    if (i_status.start_clear) begin
                        n_state  = hba_pkg::ST_CLEAR;
                        n_report = 1'b1;
                    end else begin
                        n_state = hba_pkg::ST_READ;
                    end
                end
            end
            hba_pkg::ST_READ: begin
                n_state = hba_pkg::ST_UPDATE;
            end
            hba_pkg::ST_UPDATE: begin
                n_state = hba_pkg::ST_IDLE;
            end
            hba_pkg::ST_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state  = hba_pkg::ST_IDLE;
                    n_report = 1'b0;
                end
            end
            default: begin
                n_state = hba_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd            = '0;
        o_cmd.load       = accept;
        o_cmd.clr_begin  = accept && i_status.start_clear;
        o_cmd.lookup     = (r_state == hba_pkg::ST_READ);
        o_cmd.update     = (r_state == hba_pkg::ST_UPDATE);
        o_cmd.clear      = (r_state == hba_pkg::ST_CLEAR);
        o_cmd.clr_report = (r_state == hba_pkg::ST_CLEAR) && r_report;
        o_busy           = (r_state != hba_pkg::ST_IDLE);
    end

endmodule

/* hdl/hba_dp.sv */
// bin store, counters and sums of the histogram bin accumulator
`timescale 1ns / 1ps

module hba_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  hba_pkg::t_dp_cmd           i_cmd,
    output hba_pkg::t_dp_status        o_status,
    input  logic [1:0]                 i_command,
    input  logic signed [hba_pkg::BIN_W-1:0] i_bin,
    input  logic [hba_pkg::RIDX_W-1:0] i_read_index,
    input  logic [hba_pkg::NB_W-1:0]   i_num_bins,
    output logic                       o_valid,
    output logic                       o_accepted,
    output logic [31:0]                o_bin_value,
    output logic [31:0]                o_hit_count,
    output logic [31:0]                o_underflow_count,
    output logic [31:0]                o_overflow_count,
    output logic [63:0]                o_sum_of_bins,
    output logic [63:0]                o_sum_of_squares
);

    localparam int AW = hba_pkg::ADDR_W;
    localparam int LW = hba_pkg::LIM_W;

    logic [31:0] r_mem [hba_pkg::MAX_BINS];

    // latched word
    logic [1:0]                  r_cmd;
    logic [hba_pkg::BIN_W-1:0]   r_bin;
    logic [AW-1:0]               r_addr;
    logic                        r_ridx_ok;

    // lookup stage
    logic                        r_hit, r_under, r_over;
    logic [hba_pkg::SQ_W-1:0]    r_sq;
    logic [31:0]                 r_rdata;

    // counters and result
    logic [31:0] r_hits, r_unders, r_overs;
    logic [63:0] r_bsum, r_ssum;
    logic        r_valid, r_accepted;
    logic [31:0] r_bin_value;
    logic [AW-1:0] r_clr_addr;

    logic [31:0]   bin_ext, ridx_ext;
    logic [LW-1:0] num_ext, in_use, bin_p1;
    logic          cls_hit;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          is_add;

    assign bin_ext  = 32'(i_bin[hba_pkg::BIN_W-2:0]);
    assign ridx_ext = 32'(i_read_index);

    assign o_status.start_clear = (i_command == hba_pkg::CMD_CLEAR);
    assign o_status.clr_last    = (r_clr_addr == AW'(hba_pkg::MAX_BINS - 1));

    // a hit lands when 0 <= bin < min(num_bins, MAX_BINS) - 1
    assign num_ext = LW'(i_num_bins);
    assign in_use  = (num_ext > LW'(hba_pkg::MAX_BINS)) ? LW'(hba_pkg::MAX_BINS) : num_ext;
    assign bin_p1  = LW'(r_bin[hba_pkg::BIN_W-2:0]) + LW'(1);
    assign cls_hit = !r_bin[hba_pkg::BIN_W-1] && (bin_p1 < in_use);

    assign is_add = (r_cmd == hba_pkg::CMD_ADD);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = r_rdata + 32'd1;
        if (i_cmd.clear) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (i_cmd.update && is_add && r_hit) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.lookup) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd     <= i_command;
            r_bin     <= i_bin;
            r_ridx_ok <= (ridx_ext < 32'(hba_pkg::MAX_BINS));
            if (i_command == hba_pkg::CMD_ADD) begin
                r_addr <= bin_ext[AW-1:0];
            end else begin
                r_addr <= ridx_ext[AW-1:0];
            end
        end
        if (i_cmd.lookup) begin
            r_hit   <= cls_hit;
            r_under <= r_bin[hba_pkg::BIN_W-1];
            r_over  <= !r_bin[hba_pkg::BIN_W-1] && !cls_hit;
            r_sq    <= hba_pkg::SQ_W'(r_addr) * hba_pkg::SQ_W'(r_addr);
        end
        if (i_cmd.update) begin
            r_accepted <= is_add && r_hit;
            if ((r_cmd == hba_pkg::CMD_READ) && r_ridx_ok) begin
                r_bin_value <= r_rdata;
            end else begin
                r_bin_value <= '0;
            end
        end else if (i_cmd.clear) begin
            r_accepted  <= 1'b0;
            r_bin_value <= '0;
        end
    end

    // control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_clr_addr <= '0;
            r_hits     <= '0;
            r_unders   <= '0;
            r_overs    <= '0;
            r_bsum     <= '0;
            r_ssum     <= '0;
        end else begin
            r_valid <= 1'b0;
            if (i_cmd.clr_begin) begin
                r_clr_addr <= '0;
            end else if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                r_hits     <= '0;
                r_unders   <= '0;
                r_overs    <= '0;
                r_bsum     <= '0;
                r_ssum     <= '0;
                r_valid    <= i_cmd.clr_report && o_status.clr_last;
            end else if (i_cmd.update) begin
                r_valid <= 1'b1;
                if (is_add && r_hit) begin
                    r_hits <= r_hits + 32'd1;
                    r_bsum <= r_bsum + 64'(r_addr);
                    r_ssum <= r_ssum + 64'(r_sq);
                end
                if (is_add && r_under) begin
                    r_unders <= r_unders + 32'd1;
                end
                if (is_add && r_over) begin
                    r_overs <= r_overs + 32'd1;
                end
            end
        end
    end

    assign o_valid           = r_valid;
    assign o_accepted        = r_accepted;
    assign o_bin_value       = r_bin_value;
    assign o_hit_count       = r_hits;
    assign o_underflow_count = r_unders;
    assign o_overflow_count  = r_overs;
    assign o_sum_of_bins     = r_bsum;
    assign o_sum_of_squares  = r_ssum;

endmodule

/* hdl/histogram_bin_accumulator.sv */
// top level of the histogram bin accumulator: config port, controller and datapath
// add, read and unknown commands: a taken word passes through lookup and update, then its result
// is shown on o_valid; busy holds off the next word until the store's read-modify-write is done
// clear: sweeps the 4096-entry store one entry a cycle, then shows its result word
// reset: synchronous, then a clearing pass over the whole store with busy high; config writes still taken
// the receiver cannot stall: every result word is shown for exactly one cycle
`timescale 1ns / 1ps

module histogram_bin_accumulator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // command channel
    input  logic                       start,
    output logic                       busy,
    input  logic [1:0]                 i_command,
    input  logic signed [hba_pkg::BIN_W-1:0] i_bin,
    input  logic [hba_pkg::RIDX_W-1:0] i_read_index,
    // result channel
    output logic                       o_valid,
    output logic                       o_accepted,
    output logic [31:0]                o_bin_value,
    output logic [31:0]                o_hit_count,
    output logic [31:0]                o_underflow_count,
    output logic [31:0]                o_overflow_count,
    output logic [63:0]                o_sum_of_bins,
    output logic [63:0]                o_sum_of_squares,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic [hba_pkg::NB_W-1:0] r_num_bins;
    hba_pkg::t_dp_cmd         dp_cmd;
    hba_pkg::t_dp_status      dp_status;
    logic                     cfg_wr;

    // num_bins sits at byte address 0; address 4 reads as zero and ignores writes
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? 32'd0 : 32'(r_num_bins);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_bins <= hba_pkg::NUM_BINS_RST;
        end else if (cfg_wr && !paddr[2]) begin
            r_num_bins <= pwdata[hba_pkg::NB_W-1:0];
        end
    end

    // state machine: idle, lookup, update, clearing sweep
    hba_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (dp_status),
        .o_cmd    (dp_cmd),
        .o_busy   (busy)
    );

    // bin store with registered read, counters and 64-bit sums
    hba_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_status          (dp_status),
        .i_command         (i_command),
        .i_bin             (i_bin),
        .i_read_index      (i_read_index),
        .i_num_bins        (r_num_bins),
        .o_valid           (o_valid),
        .o_accepted        (o_accepted),
        .o_bin_value       (o_bin_value),
        .o_hit_count       (o_hit_count),
        .o_underflow_count (o_underflow_count),
        .o_overflow_count  (o_overflow_count),
        .o_sum_of_bins     (o_sum_of_bins),
        .o_sum_of_squares  (o_sum_of_squares)
    );

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench of the histogram bin accumulator: commands, results, num_bins sweep
`timescale 1ns / 1ps

module tb_top;

    localparam int         MAX_BINS      = hba_pkg::MAX_BINS;
    localparam int         NB_W          = hba_pkg::NB_W;
    localparam int         BIN_W         = hba_pkg::BIN_W;
    localparam int         RIDX_W        = hba_pkg::RIDX_W;
    // command code that the block takes but ignores
    localparam logic [1:0] CMD_NOP       = 2'd3;
    localparam logic [2:0] ADDR_NUM_BINS = 3'd0;
    localparam int         DRAIN_CYCLES  = 20;
    // a clear sweeps the whole store, so quiet stretches as long as the sweep are normal
    localparam int         STALL_LIMIT   = 20000;
    localparam int         PHASE_WORDS   = 140;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [BIN_W-1:0]  bin;
        logic [RIDX_W-1:0] ridx;
    } t_hist_cmd;

    typedef struct packed {
        logic        accepted;
        logic [31:0] bin_value;
        logic [31:0] hit_count;
        logic [31:0] underflow_count;
        logic [31:0] overflow_count;
        logic [63:0] sum_of_bins;
        logic [63:0] sum_of_squares;
    } t_hist_report;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               i_command;
    logic signed [BIN_W-1:0]  i_bin;
    logic [RIDX_W-1:0]        i_read_index;
    logic                     o_valid;
    logic                     o_accepted;
    logic [31:0]              o_bin_value;
    logic [31:0]              o_hit_count;
    logic [31:0]              o_underflow_count;
    logic [31:0]              o_overflow_count;
    logic [63:0]              o_sum_of_bins;
    logic [63:0]              o_sum_of_squares;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [2:0]               paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    // shadow copy of the histogram, kept in step with every taken word
    bit [31:0]       bin_counts [MAX_BINS];
    bit [31:0]       hits_placed;
    bit [31:0]       underflows;
    bit [31:0]       overflows;
    bit [63:0]       bin_sum;
    bit [63:0]       square_sum;
    bit [NB_W-1:0]   num_bins = hba_pkg::NUM_BINS_RST;

    t_hist_cmd       cmd_queue [$];
    t_hist_report    expected_reports [$];
    int              idle_pct = 0;
    int              errors = 0;
    int              quiet_cycles = 0;
    bit              cmd_taken = 1'b0;

    histogram_bin_accumulator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_command         (i_command),
        .i_bin             (i_bin),
        .i_read_index      (i_read_index),
        .o_valid           (o_valid),
        .o_accepted        (o_accepted),
        .o_bin_value       (o_bin_value),
        .o_hit_count       (o_hit_count),
        .o_underflow_count (o_underflow_count),
        .o_overflow_count  (o_overflow_count),
        .o_sum_of_bins     (o_sum_of_bins),
        .o_sum_of_squares  (o_sum_of_squares),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // apply one command word to the shadow histogram and return the report it should give
    function automatic t_hist_report histogram_update(t_hist_cmd c);
        t_hist_report r;
        int           in_use;
        int           b;
        r      = '0;
        // num_bins beyond the store behaves as the full store
        in_use = (int'(num_bins) > MAX_BINS) ? MAX_BINS : int'(num_bins);
        b      = {{(32-BIN_W){c.bin[BIN_W-1]}}, c.bin};
        case (c.cmd)
            hba_pkg::CMD_ADD: begin
                if (b < 0) begin
                    underflows++;
                end else if (b >= in_use - 1) begin
                    // the last bin in use is never filled; num_bins of 0 or 1 fills nothing
                    overflows++;
                end else begin
                    bin_counts[b]++;
                    hits_placed++;
                    bin_sum    += 64'(b);
                    square_sum += 64'(b) * 64'(b);
                    r.accepted  = 1'b1;
                end
            end
            hba_pkg::CMD_READ: begin
                r.bin_value = bin_counts[c.ridx];
            end
            hba_pkg::CMD_CLEAR: begin
                foreach (bin_counts[i]) bin_counts[i] = '0;
                hits_placed = '0;
                underflows  = '0;
                overflows   = '0;
                bin_sum     = '0;
                square_sum  = '0;
            end
            default: begin
            end
        endcase
        r.hit_count       = hits_placed;
        r.underflow_count = underflows;
        r.overflow_count  = overflows;
        r.sum_of_bins     = bin_sum;
        r.sum_of_squares  = square_sum;
        return r;
    endfunction

    // mostly hits in or just past the bins in use, with noise, reads, ignored codes, clears
    function automatic t_hist_cmd random_command(int in_use);
        t_hist_cmd c;
        int        pick;
        int        top;
        pick   = $urandom_range(99);
        top    = ($urandom_range(1) != 0) ? ((in_use < 40) ? in_use : 40) : in_use + 2;
        c.cmd  = hba_pkg::CMD_ADD;
        c.bin  = BIN_W'($urandom);
        c.ridx = RIDX_W'($urandom);
        if (pick < 70) begin
            c.bin = BIN_W'($urandom_range(top));
        end else if (pick < 80) begin
            c.cmd = hba_pkg::CMD_ADD;
        end else if (pick < 95) begin
            c.cmd = hba_pkg::CMD_READ;
            if ($urandom_range(1) != 0)
                c.ridx = RIDX_W'($urandom_range((top > MAX_BINS - 1) ? MAX_BINS - 1 : top));
        end else if (pick < 99) begin
            c.cmd = CMD_NOP;
        end else begin
            c.cmd = hba_pkg::CMD_CLEAR;
        end
        return c;
    endfunction

    task automatic push_cmd(logic [1:0] cmd, int bin, int ridx);
        t_hist_cmd c;
        c.cmd  = cmd;
        c.bin  = BIN_W'(bin);
        c.ridx = RIDX_W'(ridx);
        cmd_queue.push_back(c);
    endtask

    // returns at a rising edge once the block has taken and answered everything
    task automatic wait_drained();
        do @(posedge i_clk);
        while (cmd_queue.size() != 0 || start || expected_reports.size() != 0);
    endtask

    task automatic write_num_bins(logic [NB_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_NUM_BINS;
        pwdata  <= 32'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk);
        while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // driver: a new word goes out once the previous one was taken, or the line is idle
    always @(negedge i_clk) begin
        t_hist_cmd nxt;
        if (i_rst_n && (!start || cmd_taken)) begin
            if (cmd_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
                nxt = cmd_queue.pop_front();
                start        <= 1'b1;
                i_command    <= nxt.cmd;
                i_bin        <= nxt.bin;
                i_read_index <= nxt.ridx;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: predicts on every taken word, checks every result word, guards against a hang
    always @(posedge i_clk) begin
        t_hist_cmd    c;
        t_hist_report want;
        logic         moved;
        moved     = 1'b0;
        cmd_taken = start && !busy;
        if (cmd_taken) begin
            c.cmd  = i_command;
            c.bin  = i_bin;
            c.ridx = i_read_index;
            expected_reports.push_back(histogram_update(c));
            moved = 1'b1;
        end
        if (psel && penable && pwrite && pready) begin
            if (paddr == ADDR_NUM_BINS)
                num_bins = pwdata[NB_W-1:0];
            moved = 1'b1;
        end
        if (i_rst_n && o_valid) begin
            moved = 1'b1;
            if (expected_reports.size() == 0) begin
                $display("%0t: result word with none expected", $time);
                errors++;
            end else begin
                want = expected_reports.pop_front();
                check_field("accepted", 64'(want.accepted), 64'(o_accepted));
                check_field("bin_value", 64'(want.bin_value), 64'(o_bin_value));
                check_field("hit_count", 64'(want.hit_count), 64'(o_hit_count));
                check_field("underflow_count", 64'(want.underflow_count),
                            64'(o_underflow_count));
                check_field("overflow_count", 64'(want.overflow_count),
                            64'(o_overflow_count));
                check_field("sum_of_bins", want.sum_of_bins, o_sum_of_bins);
                check_field("sum_of_squares", want.sum_of_squares, o_sum_of_squares);
            end
        end
        if (!i_rst_n || moved)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int nb_sets [9];
        int in_use;
        start        = 1'b0;
        i_command    = hba_pkg::CMD_ADD;
        i_bin        = '0;
        i_read_index = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = ADDR_NUM_BINS;
        pwdata       = '0;
        i_rst_n      = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // register write lands while the store is still being cleared after reset
        write_num_bins(NB_W'(MAX_BINS));

        // directed: field extremes, the unfilled last bin, ignored code, clear
        push_cmd(hba_pkg::CMD_ADD, 0, 0);
        push_cmd(hba_pkg::CMD_ADD, 1, 0);
        push_cmd(hba_pkg::CMD_ADD, MAX_BINS - 2, 0);
        push_cmd(hba_pkg::CMD_ADD, MAX_BINS - 1, 0);
        push_cmd(hba_pkg::CMD_ADD, 65535, 0);
        push_cmd(hba_pkg::CMD_ADD, -1, 0);
        push_cmd(hba_pkg::CMD_ADD, -65536, 0);
        push_cmd(hba_pkg::CMD_ADD, 1, 0);
        push_cmd(hba_pkg::CMD_READ, 0, 0);
        push_cmd(hba_pkg::CMD_READ, 0, 1);
        push_cmd(hba_pkg::CMD_READ, 0, MAX_BINS - 2);
        push_cmd(hba_pkg::CMD_READ, -1, MAX_BINS - 1);
        push_cmd(CMD_NOP, -65536, MAX_BINS - 1);
        push_cmd(CMD_NOP, 65535, 0);
        push_cmd(hba_pkg::CMD_CLEAR, -1, MAX_BINS - 1);
        push_cmd(hba_pkg::CMD_READ, 0, 1);
        push_cmd(hba_pkg::CMD_ADD, 7, 0);
        push_cmd(hba_pkg::CMD_READ, 0, 7);

        // phases sweep num_bins through its extremes; full drain between them
        nb_sets = '{4096, 8191, 37, 2, 0, 1, 4095, 4097, 300};
        for (int p = 0; p < 9; p++) begin
            wait_drained();
            write_num_bins(NB_W'(nb_sets[p]));
            idle_pct = (p % 4 == 1) ? 80 : (p % 4 == 2) ? 14 : 0;
            in_use   = (nb_sets[p] > MAX_BINS) ? MAX_BINS : nb_sets[p];
            repeat (PHASE_WORDS) cmd_queue.push_back(random_command(in_use));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* filelist.f */
hdl/hba_pkg.sv
hdl/hba_ctrl.sv
hdl/hba_dp.sv
hdl/histogram_bin_accumulator.sv
tb/sv/tb_top.sv
